// ===== rtl/debug_packet_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// debug packet deframer assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DEBUG_PACKET_DEFRAMER_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define DPD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DPD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DPD_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define DPD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared characters, event kinds and result type of the packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

  // framing characters
  localparam logic [7:0] CH_START  = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ESCAPE = 8'h7D;
  localparam logic [7:0] CH_ACK    = 8'h2B;
  localparam logic [7:0] CH_NAK    = 8'h2D;
  localparam logic [7:0] CH_INTR   = 8'h03;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] RESTART_DATA = 8'h00;

  // event kinds on the output channel
  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_FAIL    = 3'd2,
    EV_RESTART = 3'd3,
    EV_INTR    = 3'd4
  } dpd_kind_t;

  // one result item
  typedef struct packed {
    dpd_kind_t  kind;
    logic [7:0] data;
  } dpd_result_t;

endpackage

`default_nettype wire

// ===== rtl/dpd_rx_if.sv =====
// ----------------------------------------------------------------------------
// dpd_rx_if
// Received byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpd_event_if.sv =====
// ----------------------------------------------------------------------------
// dpd_event_if
// Event channel: valid/ready handshake with an event kind and a data byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dpd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] data_byte;

  modport source (output valid, output event_kind, output data_byte, input ready);
  modport sink (input valid, input event_kind, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpd_step.sv =====
// ----------------------------------------------------------------------------
// dpd_step
// Framing state and per-byte decode: checksum, escapes and trailer check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "debug_packet_deframer_assert.svh"

module dpd_step
  import dpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [7:0]  rx_byte,
  output dpd_result_t      res,
  output logic             res_valid
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic       escape_pending, escape_pending_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       digit_bad, digit_bad_next;
  logic [4:0] digit;
  logic       sum_ok;

  // hex digit value, bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        hex_value = {1'b0, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        hex_value = {1'b0, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        hex_value = {1'b0, d[3:0]};
      end else begin
        hex_value = 5'h10;
      end
    end
  endfunction

  assign digit  = hex_value(rx_byte);
  assign sum_ok = !digit_bad && !digit[4] && ({high_nibble, digit[3:0]} == running_sum);

  // next state and result for the byte in hand
  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    escape_pending_next = escape_pending;
    high_nibble_next    = high_nibble;
    digit_bad_next      = digit_bad;
    res_valid           = 1'b0;
    res.kind            = EV_DATA;
    res.data            = rx_byte;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == CH_START) begin
          phase_next          = PH_BODY;
          running_sum_next    = 8'h00;
          escape_pending_next = 1'b0;
        end else if (rx_byte == CH_INTR) begin
          res_valid = 1'b1;
          res.kind  = EV_INTR;
          res.data  = CH_INTR;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_START) begin
          running_sum_next    = 8'h00;
          escape_pending_next = 1'b0;
          res_valid           = 1'b1;
          res.kind            = EV_RESTART;
          res.data            = RESTART_DATA;
        end else if (rx_byte == CH_HASH) begin
          escape_pending_next = 1'b0;
          phase_next          = PH_HIGH;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            res_valid           = 1'b1;
            res.data            = rx_byte ^ ESC_XOR;
          end else if (rx_byte == CH_ESCAPE) begin
            escape_pending_next = 1'b1;
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        digit_bad_next   = digit[4];
        high_nibble_next = digit[3:0];
        phase_next       = PH_LOW;
      end
      PH_LOW: begin
        phase_next          = PH_IDLE;
        running_sum_next    = 8'h00;
        escape_pending_next = 1'b0;
        high_nibble_next    = 4'h0;
        digit_bad_next      = 1'b0;
        res_valid           = 1'b1;
        res.kind            = sum_ok ? EV_ACCEPT : EV_FAIL;
        res.data            = sum_ok ? CH_ACK : CH_NAK;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // framing state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      running_sum    <= 8'h00;
      escape_pending <= 1'b0;
      high_nibble    <= 4'h0;
      digit_bad      <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      escape_pending <= escape_pending_next;
      high_nibble    <= high_nibble_next;
      digit_bad      <= digit_bad_next;
    end
  end

  `DPD_ASSERT_IMP(a_esc_only_in_body, clk, rst, (phase != PH_BODY), (!escape_pending), "escape flag outside payload")
  `DPD_ASSERT_NEXT(a_end_clears, clk, rst, (advance && phase == PH_LOW), (phase == PH_IDLE && running_sum == 8'h00 && high_nibble == 4'h0 && !digit_bad), "state not cleared after trailer")
  `DPD_ASSERT_IMP(a_restart_in_body, clk, rst, (res_valid && res.kind == EV_RESTART), (phase == PH_BODY), "restart outside payload")

endmodule

`default_nettype wire

// ===== rtl/debug_packet_deframer.sv =====
// A byte enters the input register; a result is offered by the result register.
// Throughput: one byte per cycle while results are taken; while a result waits,
// the input register takes one more byte and then the input stalls.
// Reset (synchronous, rst high): framing returns to idle, checksum and flags
// clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Byte-stream deframer for the debug link: payload, acks and interrupts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "debug_packet_deframer_assert.svh"

module debug_packet_deframer
  import dpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  dpd_rx_if.sink       rx,
  dpd_event_if.source  ev
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic        out_free;
  logic        s1_adv;
  dpd_result_t res;
  logic        res_valid;

  // handshake: the input stage moves whenever the result register can take
  assign out_free = !out_valid || ev.ready;
  assign s1_adv   = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  assign ev.valid      = out_valid;
  assign ev.event_kind = out_kind;
  assign ev.data_byte  = out_data;

  // per-byte decode and framing state
  dpd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_adv),
    .rx_byte   (s1_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  // input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      if (out_free) begin
        out_valid <= s1_adv && res_valid;
      end
    end
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (s1_adv && res_valid) begin
      out_kind <= res.kind;
      out_data <= res.data;
    end
  end

  `DPD_ASSERT_IMP(a_ack_char, clk, rst,
    (ev.valid && ev.event_kind == EV_ACCEPT), (ev.data_byte == CH_ACK),
    "accept without ack char")
  `DPD_ASSERT_IMP(a_nak_char, clk, rst,
    (ev.valid && ev.event_kind == EV_FAIL), (ev.data_byte == CH_NAK),
    "fail without nak char")
  `DPD_ASSERT_NEXT(a_item_held, clk, rst,
    (s1_valid && !out_free), (s1_valid && $stable(s1_byte)),
    "stalled item lost")

endmodule

`default_nettype wire

// ===== bench/dpd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_tb_pkg
// Frame predictor and event scoreboard for the debug packet deframer bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpd_tb_pkg;
  import dpd_pkg::*;

  // framing states of the predictor
  typedef enum logic [1:0] {
    WAIT_START = 2'd0,
    IN_BODY    = 2'd1,
    SUM_HIGH   = 2'd2,
    SUM_LOW    = 2'd3
  } frame_state_t;

  // hex digit value, 16 for anything that is not a hex digit
  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  class dpd_frame_scoreboard;
    frame_state_t state;
    logic [7:0]   sum;
    bit           esc;
    logic [3:0]   hi_nib;
    bit           hi_bad;
    dpd_result_t  expected_events[$];
    int           errors;
    int           checked;

    function new();
      clear_frame();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_frame();
      state  = WAIT_START;
      sum    = 8'h00;
      esc    = 1'b0;
      hi_nib = 4'h0;
      hi_bad = 1'b0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // work out the event, if any, that one accepted byte causes
    function void note_byte(logic [7:0] b);
      dpd_result_t r;
      logic [4:0]  v;
      bit          ok;
      bit          emit;
      emit = 1'b0;
      r.kind = EV_DATA;
      r.data = 8'h00;
      case (state)
        WAIT_START: begin
          if (b == CH_START) begin
            state = IN_BODY;
            sum   = 8'h00;
            esc   = 1'b0;
          end else if (b == CH_INTR) begin
            r.kind = EV_INTR;
            r.data = CH_INTR;
            emit   = 1'b1;
          end
        end
        IN_BODY: begin
          if (b == CH_START) begin
            // restart, even straight after an escape
            sum    = 8'h00;
            esc    = 1'b0;
            r.kind = EV_RESTART;
            r.data = RESTART_DATA;
            emit   = 1'b1;
          end else if (b == CH_HASH) begin
            // a pending escape is dropped
            esc   = 1'b0;
            state = SUM_HIGH;
          end else begin
            sum = sum + b;
            if (esc) begin
              esc    = 1'b0;
              r.data = b ^ ESC_XOR;
              emit   = 1'b1;
            end else if (b == CH_ESCAPE) begin
              esc = 1'b1;
            end else begin
              r.data = b;
              emit   = 1'b1;
            end
          end
        end
        SUM_HIGH: begin
          v      = digit_value(b);
          hi_bad = v[4];
          hi_nib = v[3:0];
          state  = SUM_LOW;
        end
        default: begin
          v  = digit_value(b);
          ok = !hi_bad && !v[4] && ({hi_nib, v[3:0]} == sum);
          clear_frame();
          if (ok) begin
            r.kind = EV_ACCEPT;
            r.data = CH_ACK;
          end else begin
            r.kind = EV_FAIL;
            r.data = CH_NAK;
          end
          emit = 1'b1;
        end
      endcase
      if (emit) expected_events.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one taken event with the oldest expectation
    task check_result(logic [2:0] kind, logic [7:0] data);
      dpd_result_t want;
      checked++;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d data %02h", kind, data));
        return;
      end
      want = expected_events.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("event kind %0d, wanted %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("data byte %02h, wanted %02h", data, want.data));
    endtask
  endclass

endpackage

// ===== bench/debug_packet_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// debug_packet_deframer_tb
// Feeds directed and random byte streams (framed packets with escapes, bad
// checksums, restarts and idle noise) under several idling mixes, and checks
// every event against an in-bench frame predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debug_packet_deframer_tb;
  import dpd_pkg::*;
  import dpd_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  dpd_rx_if    rx_link ();
  dpd_event_if event_link ();

  debug_packet_deframer dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_link),
    .ev  (event_link)
  );

  dpd_frame_scoreboard sb;

  int send_idle_pct;
  int stall_pct;
  int bytes_sent;
  int packets_sent;
  int cycle_count;
  bit hold_req;
  bit hold_done;
  int hold_left;

  // short directed stream: idle noise, escapes, restarts and bad digits
  logic [7:0] directed_bytes [28] = '{
    8'h00, 8'hFF, CH_INTR, CH_HASH,
    CH_START, 8'hFF, CH_INTR, CH_ESCAPE, 8'h2C, CH_HASH, 8'h41, 8'h42,
    CH_START, 8'h41, CH_ESCAPE, CH_START, CH_ESCAPE, CH_HASH, 8'h37, 8'h64,
    CH_START, CH_HASH, 8'h47, 8'h30,
    CH_START, CH_HASH, 8'h30, CH_START
  };

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // event receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (!rst && event_link.valid && event_link.ready)
      sb.check_result(event_link.event_kind, event_link.data_byte);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_link.ready <= 1'b0;
    end else begin
      event_link.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one byte, with random idle cycles first
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_link.valid <= 1'b0;
      @(posedge clk);
    end
    rx_link.valid   <= 1'b1;
    rx_link.rx_byte <= b;
    @(posedge clk);
    while (!rx_link.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // one random packet, mostly well formed, sometimes broken
  task automatic send_packet();
    int         len;
    int         mode;
    int         roll;
    logic [7:0] sum;
    logic [7:0] p;
    logic [7:0] noise;
    logic [7:0] bad;
    // idle noise between packets, interrupts among it
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        noise = $urandom_range(1) ? CH_INTR : 8'($urandom);
        if (noise == CH_START) noise = CH_INTR;
        send_byte(noise);
      end
    end
    mode = $urandom_range(19);
    len  = ($urandom_range(15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    sum  = 8'h00;
    send_byte(CH_START);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(9);
      if (roll == 0) begin
        case ($urandom_range(3))
          0: p = CH_HASH;
          1: p = CH_START;
          2: p = CH_ESCAPE;
          default: p = CH_INTR;
        endcase
      end else begin
        p = 8'($urandom);
      end
      // framing characters must travel escaped
      if ((p == CH_HASH || p == CH_START || p == CH_ESCAPE || roll == 1) &&
          (p ^ ESC_XOR) != CH_HASH && (p ^ ESC_XOR) != CH_START) begin
        send_byte(CH_ESCAPE);
        send_byte(p ^ ESC_XOR);
        sum = sum + CH_ESCAPE + (p ^ ESC_XOR);
      end else begin
        send_byte(p);
        sum = sum + p;
      end
    end
    // broken framing: restart inside the body, or escape right before the hash
    if (mode == 0) begin
      send_byte(CH_START);
      sum = 8'h00;
    end else if (mode == 1) begin
      send_byte(CH_ESCAPE);
      sum = sum + CH_ESCAPE;
    end
    send_byte(CH_HASH);
    if (mode == 2) sum = sum ^ 8'($urandom_range(1, 255));
    bad = 8'($urandom);
    while (digit_value(bad) != 5'd16) bad = 8'($urandom);
    send_byte((mode == 3) ? bad : hex_char(sum[7:4], 1'($urandom_range(1))));
    send_byte((mode == 4) ? bad : hex_char(sum[3:0], 1'($urandom_range(1))));
    packets_sent++;
  endtask

  // stop offering and wait for every expected event
  task automatic wait_drained();
    rx_link.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int phase_start;
    sb = new();
    rst              = 1'b1;
    rx_link.valid    = 1'b0;
    rx_link.rx_byte  = 8'h00;
    event_link.ready = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    bytes_sent       = 0;
    packets_sent     = 0;
    cycle_count      = 0;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    hold_left        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed stream
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_drained();

    // random packets under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // long output hold-off while bytes keep coming
        if (ph == 0 && !hold_done && bytes_sent - phase_start >= 100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        send_packet();
      end
      wait_drained();
    end

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected events never arrived", sb.pending()));
    $display("covered %0d bytes in %0d random packets plus directed cases", bytes_sent,
             packets_sent);
    $display("checked %0d events over four idling mixes and a long output hold-off",
             sb.checked);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== debug_packet_deframer.f =====
+incdir+rtl
rtl/dpd_pkg.sv
rtl/dpd_rx_if.sv
rtl/dpd_event_if.sv
rtl/dpd_step.sv
rtl/debug_packet_deframer.sv
bench/dpd_tb_pkg.sv
bench/debug_packet_deframer_tb.sv
